// ===== rtl/shs_pkg.sv =====
// Shared types, constants and functions for the SHA-256 stream hash block.
package shs_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned NUM_ROUNDS = 64;
   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam logic [5:0] LAST_FILL = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD = 3'd7;
   localparam logic [63:0] BYTE_BITS = 64'd8;

   typedef logic [7:0][WORD_W-1:0] hash_words_type;

   localparam hash_words_type INITIAL_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [WORD_W-1:0] ROUND_K [NUM_ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_ADD
   } core_state_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPRESS,
      ST_PAD,
      ST_OUTPUT
   } top_state_type;

   typedef struct packed {
      logic       shift;
      logic [7:0] data;
      logic       start;
      logic       init;
   } core_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_stat_type;

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                              input int unsigned n);
      return (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

// ===== rtl/shs_core.sv =====
// SHA-256 compression unit: byte-loaded schedule window, one round per cycle.
module shs_core (
   input  logic                   clock,
   input  logic                   reset,
   input  shs_pkg::core_ctrl_type ctrl,
   output shs_pkg::core_stat_type stat,
   output shs_pkg::hash_words_type hash
);

   shs_pkg::core_state_type  state_ff, state_in;
   logic [5:0]               round_ff, round_in;
   shs_pkg::hash_words_type  hash_ff, hash_in;
   shs_pkg::hash_words_type  vars_ff, vars_in;
   logic [511:0]             win_ff, win_in;

   logic [31:0] w0, w1, w9, w14, w_new;
   logic [31:0] t1, t2;

   assign w0  = win_ff[511:480];
   assign w1  = win_ff[479:448];
   assign w9  = win_ff[223:192];
   assign w14 = win_ff[63:32];

   assign w_new = shs_pkg::small_sigma1(w14) + w9 + shs_pkg::small_sigma0(w1) + w0;

   assign t1 = vars_ff[7] + shs_pkg::big_sigma1(vars_ff[4])
             + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
             + shs_pkg::ROUND_K[round_ff] + w0;
   assign t2 = shs_pkg::big_sigma0(vars_ff[0])
             + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
               ^ (vars_ff[1] & vars_ff[2]));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= shs_pkg::CORE_IDLE;
         round_ff <= '0;
         hash_ff  <= shs_pkg::INITIAL_HASH;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         hash_ff  <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
      win_ff  <= win_in;
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      hash_in  = hash_ff;
      vars_in  = vars_ff;
      win_in   = win_ff;
      if (ctrl.shift) begin
         win_in = {win_ff[503:0], ctrl.data};
      end
      unique case (state_ff)
         shs_pkg::CORE_IDLE: begin
            if (ctrl.start) begin
               vars_in  = hash_ff;
               round_in = '0;
               state_in = shs_pkg::CORE_ROUND;
            end
         end
         shs_pkg::CORE_ROUND: begin
            vars_in[7] = vars_ff[6];
            vars_in[6] = vars_ff[5];
            vars_in[5] = vars_ff[4];
            vars_in[4] = vars_ff[3] + t1;
            vars_in[3] = vars_ff[2];
            vars_in[2] = vars_ff[1];
            vars_in[1] = vars_ff[0];
            vars_in[0] = t1 + t2;
            win_in     = {win_ff[479:0], w_new};
            round_in   = round_ff + 6'd1;
            if (round_ff == shs_pkg::LAST_ROUND) begin
               state_in = shs_pkg::CORE_ADD;
            end
         end
         shs_pkg::CORE_ADD: begin
            for (int k = 0; k < 8; k++) begin
               hash_in[k] = hash_ff[k] + vars_ff[k];
            end
            state_in = shs_pkg::CORE_IDLE;
         end
         default: begin
            state_in = shs_pkg::CORE_IDLE;
         end
      endcase
      if (ctrl.init) begin
         hash_in = shs_pkg::INITIAL_HASH;
      end
   end

   assign stat.idle = (state_ff == shs_pkg::CORE_IDLE);
   assign stat.done = (state_ff == shs_pkg::CORE_ADD);
   assign hash      = hash_ff;

endmodule

// ===== rtl/sha256_stream_hash_top.sv =====
// Top level of the SHA-256 stream hash: request sequencer, padding and digest output.
//
// Usage: each request on req_ carries at most one message byte (req_has_byte) and
// may end the message (req_end_of_message). The digest comes out on rsp_ as eight
// 32-bit words, index 0 first, rsp_last_word on the eighth.
// Timing: a byte that neither completes a 64-byte block nor ends the message is
// taken and req_ready stays high. The byte that completes a block starts the
// compression unit: 64 rounds, one per cycle, plus the hash update, with
// req_ready low. An end-of-message request then shifts the padding in one byte
// per cycle, compresses one or two blocks and presents the eight digest words,
// one per cycle while rsp_ready is high.
// Only one request is in work at a time; req_ready is high only when idle.
// Reset: synchronous, active high; the hash returns to the initial values and the
// byte count and bit length clear. A stalled receiver holds the current digest
// word on rsp_ and the block waits; the hash resets to the initial values after
// the last word is taken.
module sha256_stream_hash_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   shs_pkg::top_state_type  state_ff, state_in;
   logic [5:0]              fill_ff, fill_in;
   logic [63:0]             bitlen_ff, bitlen_in;
   logic                    eom_ff, eom_in;
   logic                    pad_ff, pad_in;
   logic                    marker_ff, marker_in;
   logic                    extra_ff, extra_in;
   logic [2:0]              word_ff, word_in;

   shs_pkg::core_ctrl_type  ctrl;
   shs_pkg::core_stat_type  stat;
   shs_pkg::hash_words_type hash;

   logic       req_fire, rsp_fire;
   logic [7:0] len_byte;

   shs_core u_core (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .stat  (stat),
      .hash  (hash)
   );

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign len_byte = bitlen_ff[{~fill_ff[2:0], 3'b000} +: 8];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= shs_pkg::ST_IDLE;
         fill_ff   <= '0;
         bitlen_ff <= '0;
         eom_ff    <= 1'b0;
         pad_ff    <= 1'b0;
         marker_ff <= 1'b0;
         extra_ff  <= 1'b0;
         word_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         bitlen_ff <= bitlen_in;
         eom_ff    <= eom_in;
         pad_ff    <= pad_in;
         marker_ff <= marker_in;
         extra_ff  <= extra_in;
         word_ff   <= word_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      bitlen_in  = bitlen_ff;
      eom_in     = eom_ff;
      pad_in     = pad_ff;
      marker_in  = marker_ff;
      extra_in   = extra_ff;
      word_in    = word_ff;
      ctrl.shift = 1'b0;
      ctrl.data  = req_data_byte;
      ctrl.start = 1'b0;
      ctrl.init  = 1'b0;
      unique case (state_ff)
         shs_pkg::ST_IDLE: begin
            if (req_fire) begin
               eom_in    = req_end_of_message;
               pad_in    = 1'b0;
               marker_in = 1'b0;
               extra_in  = 1'b0;
               if (req_has_byte) begin
                  ctrl.shift = 1'b1;
                  bitlen_in  = bitlen_ff + shs_pkg::BYTE_BITS;
                  fill_in    = fill_ff + 6'd1;
               end
               if (req_has_byte && fill_ff == shs_pkg::LAST_FILL) begin
                  ctrl.start = 1'b1;
                  state_in   = shs_pkg::ST_COMPRESS;
               end else if (req_end_of_message) begin
                  pad_in   = 1'b1;
                  state_in = shs_pkg::ST_PAD;
               end
            end
         end
         shs_pkg::ST_COMPRESS: begin
            if (stat.done) begin
               if (!pad_ff) begin
                  if (eom_ff) begin
                     pad_in   = 1'b1;
                     state_in = shs_pkg::ST_PAD;
                  end else begin
                     state_in = shs_pkg::ST_IDLE;
                  end
               end else if (extra_ff) begin
                  extra_in = 1'b0;
                  state_in = shs_pkg::ST_PAD;
               end else begin
                  word_in  = '0;
                  state_in = shs_pkg::ST_OUTPUT;
               end
            end
         end
         shs_pkg::ST_PAD: begin
            ctrl.shift = 1'b1;
            fill_in    = fill_ff + 6'd1;
            if (!marker_ff) begin
               ctrl.data = shs_pkg::PAD_MARKER;
               marker_in = 1'b1;
               extra_in  = (fill_ff[5:3] == 3'b111);
            end else if (fill_ff[5:3] == 3'b111 && !extra_ff) begin
               ctrl.data = len_byte;
            end else begin
               ctrl.data = 8'h00;
            end
            if (fill_ff == shs_pkg::LAST_FILL) begin
               ctrl.start = 1'b1;
               state_in   = shs_pkg::ST_COMPRESS;
            end
         end
         shs_pkg::ST_OUTPUT: begin
            if (rsp_fire) begin
               word_in = word_ff + 3'd1;
               if (word_ff == shs_pkg::LAST_WORD) begin
                  ctrl.init = 1'b1;
                  fill_in   = '0;
                  bitlen_in = '0;
                  eom_in    = 1'b0;
                  pad_in    = 1'b0;
                  marker_in = 1'b0;
                  extra_in  = 1'b0;
                  state_in  = shs_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = shs_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_ready       = (state_ff == shs_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == shs_pkg::ST_OUTPUT);
   assign rsp_digest_word = hash[word_ff];
   assign rsp_word_index  = word_ff;
   assign rsp_last_word   = (word_ff == shs_pkg::LAST_WORD);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response sides active together");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> stat.idle)
      else $error("compression started while unit busy");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_last_word |=> req_ready && !rsp_valid)
      else $error("no return to idle after last digest word");

   a_out_fill_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (fill_ff == 6'd0) && stat.idle)
      else $error("digest presented with block data pending");

endmodule
